>>> rtl/plsm_pkg.sv
// shared types, constants and helper functions of the per-line substring matcher
`timescale 1ns / 1ps
`default_nettype none

package plsm_pkg;

  localparam int unsigned NeedleBytes  = 16;
  localparam int unsigned DefMaxNeedle = 16;
  localparam int unsigned CountW       = 32;
  localparam int unsigned LenW         = 5;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [7:0] NlByte     = 8'd10;
  localparam logic [7:0] AsciiUpA   = 8'h41;
  localparam logic [7:0] AsciiUpZ   = 8'h5a;
  localparam logic [7:0] CaseOffset = 8'd32;

  typedef logic [CountW-1:0] count_t;
  typedef logic [LenW-1:0]   len_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NEEDLE_LOW    = 2'd0,
    CFG_NEEDLE_HIGH   = 2'd1,
    CFG_NEEDLE_LENGTH = 2'd2,
    CFG_FOLD_CASE     = 2'd3
  } cfg_idx_e;

  // one queued byte outcome: first result and whether a second follows
  typedef struct packed {
    count_t line;
    count_t col;
    len_t   len;
    logic   dbl;
  } entry_t;

  typedef struct packed {
    count_t line;
    count_t col;
    len_t   len;
    logic   last;
  } result_t;

  function automatic count_t sat_inc(input count_t v);
    count_t r;
    r = (v == '1) ? v : v + count_t'(1);
    return r;
  endfunction

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    logic [7:0] r;
    r = (en && b >= AsciiUpA && b <= AsciiUpZ) ? b + CaseOffset : b;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/plsm_if.sv
// channel interfaces: content bytes, match results and register writes
`timescale 1ns / 1ps
`default_nettype none

interface plsm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_content;

  modport source (output valid, output data_byte, output end_of_content, input ready);
  modport sink   (input valid, input data_byte, input end_of_content, output ready);
endinterface

interface plsm_out_if;
  logic                   valid;
  logic                   ready;
  logic [31:0]            line_number;
  logic [31:0]            start_column;
  logic [4:0]             match_length;
  logic                   last_of_run;

  modport source (output valid, output line_number, output start_column,
                  output match_length, output last_of_run, input ready);
  modport sink   (input valid, input line_number, input start_column,
                  input match_length, input last_of_run, output ready);
endinterface

interface plsm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [plsm_pkg::CfgIdxW-1:0]   index;
  logic [plsm_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/per_line_substring_matcher.sv
// top level of the per-line substring matcher
//
//  channel  dir  width / payload                                   handshake
//  in_i     in   data_byte 8, end_of_content 1                     valid/ready
//  out_o    out  line_number 32, start_column 32, match_length 5,  valid/ready
//                last_of_run 1
//  cfg_i    in   index 2, data 64                                  valid/ready, always ready
//
// one content byte is taken every cycle while the queue has room; the window compare is a single stage
// results leave through an output register one per cycle while out_o is ready, so a byte that
// closes a line under an empty needle yields two results, one after the other
// a two-entry queue separates the front from the output; a stalled output
// halts input only once the queue is full
// asynchronous active-low reset clears window, counters and registers
`timescale 1ns / 1ps
`default_nettype none

module per_line_substring_matcher #(
  parameter int unsigned MAX_NEEDLE  = plsm_pkg::DefMaxNeedle,
  parameter int unsigned QUEUE_DEPTH = plsm_pkg::QueueDepth
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  plsm_in_if.sink     in_i,
  plsm_out_if.source  out_o,
  plsm_cfg_if.sink    cfg_i
);

  logic              push_valid, push_ready;
  plsm_pkg::entry_t  push_entry;
  logic              pop_valid, pop_ready;
  plsm_pkg::entry_t  pop_entry;

  plsm_front #(
    .MAX_NEEDLE (MAX_NEEDLE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  plsm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  plsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

>>> rtl/plsm_front.sv
// front end: registers, byte window, counters and match classification
`timescale 1ns / 1ps
`default_nettype none

module plsm_front #(
  parameter int unsigned MAX_NEEDLE = plsm_pkg::DefMaxNeedle
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  plsm_in_if.sink           in_i,
  plsm_cfg_if.sink          cfg_i,
  output logic              push_valid_o,
  output plsm_pkg::entry_t  push_entry_o,
  input  wire logic         push_ready_i
);

  logic [8*plsm_pkg::NeedleBytes-1:0] needle_q;
  plsm_pkg::len_t                     needle_len_q;
  logic                               fold_q;

  logic [7:0]       window_q [MAX_NEEDLE];
  logic [7:0]       win_d    [MAX_NEEDLE];
  plsm_pkg::count_t line_q, line_d;
  plsm_pkg::count_t col_q, col_d;

  logic                         accept;
  logic                         is_nl;
  logic                         closes;
  plsm_pkg::len_t               m;
  logic                         hit;
  logic                         len_ok;
  logic [plsm_pkg::CountW:0]    col_ext;
  logic [plsm_pkg::CountW:0]    start_ext;
  plsm_pkg::len_t               nidx;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = push_ready_i;
  assign accept      = in_i.valid && push_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_q     <= '0;
      needle_len_q <= '0;
      fold_q       <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        plsm_pkg::CFG_NEEDLE_LOW:    needle_q[63:0]   <= cfg_i.data;
        plsm_pkg::CFG_NEEDLE_HIGH:   needle_q[127:64] <= cfg_i.data;
        plsm_pkg::CFG_NEEDLE_LENGTH: needle_len_q     <= cfg_i.data[plsm_pkg::LenW-1:0];
        plsm_pkg::CFG_FOLD_CASE:     fold_q           <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    is_nl  = (in_i.data_byte == plsm_pkg::NlByte);
    closes = is_nl || in_i.end_of_content;
    m      = (needle_len_q > plsm_pkg::LenW'(MAX_NEEDLE)) ?
             plsm_pkg::LenW'(MAX_NEEDLE) : needle_len_q;

    win_d[0] = in_i.data_byte;
    for (int k = 1; k < MAX_NEEDLE; k++) begin
      win_d[k] = window_q[k-1];
    end

    // window position k pairs with needle byte m-1-k
    hit  = 1'b1;
    nidx = '0;
    for (int k = 0; k < MAX_NEEDLE; k++) begin
      if (plsm_pkg::LenW'(k) < m) begin
        nidx = m - plsm_pkg::len_t'(1) - plsm_pkg::LenW'(k);
        if (plsm_pkg::fold_byte(win_d[k], fold_q) !=
            plsm_pkg::fold_byte(needle_q[8*nidx[3:0] +: 8], fold_q)) begin
          hit = 1'b0;
        end
      end
    end

    col_ext   = {1'b0, col_q} + (plsm_pkg::CountW+1)'(1);
    len_ok    = col_ext >= (plsm_pkg::CountW+1)'(m);
    start_ext = col_ext - (plsm_pkg::CountW+1)'(m);

    push_entry_o.line = line_q;
    push_entry_o.col  = (m == '0) ? col_q : start_ext[plsm_pkg::CountW-1:0];
    push_entry_o.len  = m;
    push_entry_o.dbl  = (m == '0) && closes;
    push_valid_o      = in_i.valid && ((m == '0) || (len_ok && hit));

    if (in_i.end_of_content) begin
      line_d = '0;
      col_d  = '0;
    end else if (is_nl) begin
      line_d = plsm_pkg::sat_inc(line_q);
      col_d  = '0;
    end else begin
      line_d = line_q;
      col_d  = plsm_pkg::sat_inc(col_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      col_q  <= '0;
      for (int k = 0; k < MAX_NEEDLE; k++) begin
        window_q[k] <= '0;
      end
    end else if (accept) begin
      line_q <= line_d;
      col_q  <= col_d;
      for (int k = 0; k < MAX_NEEDLE; k++) begin
        window_q[k] <= in_i.end_of_content ? 8'd0 : win_d[k];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/plsm_queue.sv
// short queue of classified byte outcomes between front and back
`timescale 1ns / 1ps
`default_nettype none

module plsm_queue #(
  parameter int unsigned DEPTH = plsm_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  input  plsm_pkg::entry_t       push_entry_i,
  output logic                   push_ready_o,
  output logic                   pop_valid_o,
  output plsm_pkg::entry_t       pop_entry_o,
  input  wire logic              pop_ready_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  plsm_pkg::entry_t slots_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = slots_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_ready_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/plsm_back.sv
// back end: expands queued outcomes into result transactions
`timescale 1ns / 1ps
`default_nettype none

module plsm_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          pop_valid_i,
  input  plsm_pkg::entry_t   pop_entry_i,
  output logic               pop_ready_o,
  plsm_out_if.source         out_o
);

  logic               out_valid_q;
  plsm_pkg::result_t  res_q;
  logic               pend_q;
  plsm_pkg::count_t   pend_line_q;
  plsm_pkg::count_t   pend_col_q;
  logic               load;

  assign load        = !out_valid_q || out_o.ready;
  assign pop_ready_o = load && !pend_q;

  assign out_o.valid        = out_valid_q;
  assign out_o.line_number  = res_q.line;
  assign out_o.start_column = res_q.col;
  assign out_o.match_length = res_q.len;
  assign out_o.last_of_run  = res_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else begin
        out_valid_q <= pop_valid_i;
        pend_q      <= pop_valid_i && pop_entry_i.dbl;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        // closing column of an empty needle
        res_q.line <= pend_line_q;
        res_q.col  <= pend_col_q;
        res_q.len  <= '0;
        res_q.last <= 1'b1;
      end else if (pop_valid_i) begin
        res_q.line  <= pop_entry_i.line;
        res_q.col   <= pop_entry_i.col;
        res_q.len   <= pop_entry_i.len;
        res_q.last  <= !pop_entry_i.dbl;
        pend_line_q <= pop_entry_i.line;
        pend_col_q  <= plsm_pkg::sat_inc(pop_entry_i.col);
      end
    end
  end

endmodule

`default_nettype wire

>>> bench/testbench.sv
// testbench of the per-line substring matcher: directed table, random content, match prediction
`timescale 1ns / 1ps

module testbench;
  import plsm_pkg::*;

  localparam int MaxNeedle     = DefMaxNeedle;
  localparam int Phases        = 9;
  localparam int ItemsPerPhase = 50;
  localparam int DrainCycles   = 8;
  localparam int IdleLimit     = 2000;

  typedef enum logic {ROW_SETUP, ROW_BYTE} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    logic        fold;
    logic [7:0]  b;
    logic        eoc;
    logic        typed;
    logic [1:0]  n;
    result_t     r0;
    result_t     r1;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm = 1'b0;
  int   errors = 0;

  plsm_in_if  byte_if ();
  plsm_out_if match_if ();
  plsm_cfg_if reg_if ();

  per_line_substring_matcher dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_if),
    .out_o  (match_if),
    .cfg_i  (reg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state of the matcher
  logic [7:0]   win_bytes [MaxNeedle];
  count_t       col_now;
  count_t       line_now;
  logic [127:0] needle_bits;
  logic [4:0]   needle_len;
  logic         fold_on;

  result_t pending_matches [$];

  logic [7:0] alphabet [8] = '{8'h61, 8'h41, 8'h62, 8'h42, 8'h5a, 8'h7a, 8'h40, 8'h60};

  row_t directed_rows [31] = '{
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h61, 1'b0, 1'b1, 2'd1,
      {32'd0, 32'd0, 5'd0, 1'b1}, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h0a, 1'b0, 1'b1, 2'd2,
      {32'd0, 32'd1, 5'd0, 1'b0}, {32'd0, 32'd2, 5'd0, 1'b1}},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'hff, 1'b1, 1'b1, 2'd2,
      {32'd1, 32'd0, 5'd0, 1'b0}, {32'd1, 32'd1, 5'd0, 1'b1}},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h00, 1'b1, 1'b1, 2'd2,
      {32'd0, 32'd0, 5'd0, 1'b0}, {32'd0, 32'd1, 5'd0, 1'b1}},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h0a, 1'b1, 1'b1, 2'd2,
      {32'd0, 32'd0, 5'd0, 1'b0}, {32'd0, 32'd1, 5'd0, 1'b1}},
    // case-sensitive two-byte needle
    '{ROW_SETUP, 64'h6241, 64'h0, 5'd2, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h41, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h62, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h61, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h42, 1'b1, 1'b0, 2'd0, '0, '0},
    // folded needle, overlapping hits
    '{ROW_SETUP, 64'h6161, 64'h0, 5'd2, 1'b1, 8'h00, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h41, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h61, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h41, 1'b1, 1'b0, 2'd0, '0, '0},
    // oversized length clamps to a full sixteen-byte needle
    '{ROW_SETUP, 64'h00ff00ff00ff00ff, 64'hff00ff00ff00ff00, 5'd31, 1'b1,
      8'h00, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'hff, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'hff, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'hff, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'hff, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'hff, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'hff, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'hff, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'h00, 1'b0, 1'b0, 2'd0, '0, '0},
    '{ROW_BYTE, '0, '0, '0, 1'b0, 8'hff, 1'b1, 1'b0, 2'd0, '0, '0}
  };

  function automatic count_t bump(input count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

  function automatic logic [7:0] fold_for_compare(input logic [7:0] v);
    return (fold_on && v >= 8'h41 && v <= 8'h5a) ? v + 8'd32 : v;
  endfunction

  function automatic void queue_match(input result_t r);
    pending_matches = {pending_matches, r};
  endfunction

  function automatic void track_byte(input logic [7:0] b, input logic eoc,
                                     output result_t r0, output result_t r1, output int n);
    int   m;
    logic hit;
    logic closes;
    closes = (b == NlByte) || eoc;
    m = (needle_len > MaxNeedle) ? MaxNeedle : int'(needle_len);
    for (int k = MaxNeedle - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
    win_bytes[0] = b;
    n = 0;
    r0 = '0;
    r1 = '0;
    if (m == 0) begin
      r0 = '{line_now, col_now, 5'd0, 1'b0};
      n = 1;
      if (closes) begin
        r1 = '{line_now, bump(col_now), 5'd0, 1'b0};
        n = 2;
      end
    end else if ({1'b0, col_now} + 33'd1 >= 33'(m)) begin
      hit = 1'b1;
      for (int i = 0; i < m; i++) begin
        if (fold_for_compare(win_bytes[m-1-i]) != fold_for_compare(needle_bits[i*8 +: 8]))
          hit = 1'b0;
      end
      if (hit) begin
        r0 = '{line_now, col_now + 32'd1 - 32'(m), 5'(m), 1'b0};
        n = 1;
      end
    end
    if (n == 1) r0.last = 1'b1;
    else if (n == 2) r1.last = 1'b1;
    if (eoc) begin
      foreach (win_bytes[k]) win_bytes[k] = 8'h00;
      col_now = '0;
      line_now = '0;
    end else if (b == NlByte) begin
      col_now = '0;
      line_now = bump(line_now);
    end else begin
      col_now = bump(col_now);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eoc, input logic typed = 1'b0,
                           input logic [1:0] n_typed = 2'd0, input result_t t0 = '0,
                           input result_t t1 = '0);
    result_t p0;
    result_t p1;
    int      np;
    if (!calm && $urandom_range(5) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    byte_if.valid          <= 1'b1;
    byte_if.data_byte      <= b;
    byte_if.end_of_content <= eoc;
    do @(posedge clk); while (!byte_if.ready);
    track_byte(b, eoc, p0, p1, np);
    if (typed) begin
      if (n_typed > 0) queue_match(t0);
      if (n_typed > 1) queue_match(t1);
    end else begin
      if (np > 0) queue_match(p0);
      if (np > 1) queue_match(p1);
    end
  endtask

  task automatic drain_matches();
    byte_if.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_needle(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] len, input logic fold);
    cfg_idx_e    order [4];
    logic [63:0] vals [4];
    order = '{CFG_NEEDLE_LOW, CFG_NEEDLE_HIGH, CFG_NEEDLE_LENGTH, CFG_FOLD_CASE};
    vals  = '{lo, hi, 64'(len), 64'(fold)};
    for (int k = 0; k < 4; k++) begin
      reg_if.valid <= 1'b1;
      reg_if.index <= order[k];
      reg_if.data  <= vals[k];
      do @(posedge clk); while (!reg_if.ready);
      case (order[k])
        CFG_NEEDLE_LOW:    needle_bits[63:0]   = vals[k];
        CFG_NEEDLE_HIGH:   needle_bits[127:64] = vals[k];
        CFG_NEEDLE_LENGTH: needle_len          = vals[k][4:0];
        CFG_FOLD_CASE:     fold_on             = vals[k][0];
        default: ;
      endcase
    end
    reg_if.valid <= 1'b0;
  endtask

  // result side: checks and random stalls
  initial begin
    result_t want;
    int      stall_left;
    stall_left = 0;
    match_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && match_if.valid && match_if.ready) begin
        if (pending_matches.size() == 0) begin
          $error("unexpected match transaction: line %0d column %0d",
                 match_if.line_number, match_if.start_column);
          errors++;
        end else begin
          want = pending_matches.pop_front();
          if (match_if.line_number !== want.line) begin
            $error("line_number: expected %0d, got %0d", want.line, match_if.line_number);
            errors++;
          end
          if (match_if.start_column !== want.col) begin
            $error("start_column: expected %0d, got %0d", want.col, match_if.start_column);
            errors++;
          end
          if (match_if.match_length !== want.len) begin
            $error("match_length: expected %0d, got %0d", want.len, match_if.match_length);
            errors++;
          end
          if (match_if.last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, match_if.last_of_run);
            errors++;
          end
        end
      end
      if (stall_left != 0) stall_left--;
      else if (!calm && $urandom_range(7) == 0) stall_left = $urandom_range(1, 5);
      match_if.ready <= (stall_left == 0);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((byte_if.valid && byte_if.ready) || (match_if.valid && match_if.ready) ||
          (reg_if.valid && reg_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [8:0]   pend [$];
    logic [8:0]   item;
    logic [127:0] nd;
    logic [4:0]   len;
    logic         fold;
    logic [7:0]   nb;
    int           m;
    int           sent;
    int           r;
    int           nl_pct;
    int           eoc_pct;

    rst_n                  <= 1'b0;
    byte_if.valid          <= 1'b0;
    byte_if.data_byte      <= 8'h00;
    byte_if.end_of_content <= 1'b0;
    reg_if.valid           <= 1'b0;
    reg_if.index           <= CFG_NEEDLE_LOW;
    reg_if.data            <= '0;
    foreach (win_bytes[k]) win_bytes[k] = 8'h00;
    col_now     = '0;
    line_now    = '0;
    needle_bits = '0;
    needle_len  = '0;
    fold_on     = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SETUP) begin
        drain_matches();
        load_needle(directed_rows[i].lo, directed_rows[i].hi, directed_rows[i].len,
                    directed_rows[i].fold);
      end else begin
        send_byte(directed_rows[i].b, directed_rows[i].eoc, directed_rows[i].typed,
                  directed_rows[i].n, directed_rows[i].r0, directed_rows[i].r1);
      end
    end

    for (int p = 0; p < Phases; p++) begin
      drain_matches();
      for (int k = 0; k < MaxNeedle; k++)
        nd[k*8 +: 8] = ($urandom_range(3) != 0) ? alphabet[$urandom_range(7)]
                                                 : 8'($urandom_range(255));
      fold = 1'($urandom_range(1));
      case (p)
        0: begin nd = '0; len = 5'd16; fold = 1'b0; end
        1: begin nd = '1; len = 5'd16; fold = 1'b1; end
        2: len = 5'd0;
        3: len = 5'($urandom_range(17, 31));
        default: len = ($urandom_range(2) == 0) ? 5'($urandom_range(1, 3))
                                                : 5'($urandom_range(1, 16));
      endcase
      load_needle(nd[63:0], nd[127:64], len, fold);
      m       = (len > MaxNeedle) ? MaxNeedle : int'(len);
      nl_pct  = (m > 4) ? 2 : 10;
      eoc_pct = (m > 4) ? 1 : 4;
      if (p == Phases - 1) calm = 1'b1;
      pend.delete();
      sent = 0;
      while (sent < ItemsPerPhase) begin
        if (pend.size() == 0) begin
          r = $urandom_range(99);
          if (r < 40) begin
            for (int k = 0; k < ((m == 0) ? 1 : m); k++) begin
              nb = nd[k*8 +: 8];
              if (fold && ((nb >= 8'h41 && nb <= 8'h5a) || (nb >= 8'h61 && nb <= 8'h7a)) &&
                  $urandom_range(1) == 1)
                nb = nb ^ 8'h20;
              item = {1'b0, nb};
              pend = {pend, item};
            end
          end else if (r < 40 + nl_pct) begin
            item = {1'b0, NlByte};
            pend = {pend, item};
          end else if (r < 40 + nl_pct + eoc_pct) begin
            item = {1'b1, alphabet[$urandom_range(7)]};
            pend = {pend, item};
          end else if (r < 85) begin
            item = {1'b0, alphabet[$urandom_range(7)]};
            pend = {pend, item};
          end else if (r < 93) begin
            item = {1'b0, nd[$urandom_range(MaxNeedle - 1)*8 +: 8]};
            pend = {pend, item};
          end else begin
            item = {1'($urandom_range(1) & ($urandom_range(7) == 0)),
                    8'($urandom_range(255))};
            pend = {pend, item};
          end
        end
        item = pend.pop_front();
        send_byte(item[7:0], item[8]);
        sent++;
        // hold off mid-phase until the matcher has emptied
        if (sent == ItemsPerPhase / 2) begin
          byte_if.valid <= 1'b0;
          do @(posedge clk); while (pending_matches.size() != 0);
        end
      end
    end

    byte_if.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DrainCycles * 2) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/plsm_pkg.sv
rtl/plsm_if.sv
rtl/plsm_front.sv
rtl/plsm_queue.sv
rtl/plsm_back.sv
rtl/per_line_substring_matcher.sv
bench/testbench.sv
